@@ sv/rope_sh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rope_sh_pkg
// Shared types and constants for the split-half rotary embedding core.
// ----------------------------------------------------------------------------
package rope_sh_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int COL_W       = 6;
  localparam int DATA_W      = 16;
  localparam int HD_W        = 7;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [HD_W-1:0] HD_RESET = 7'd64;

  // request kind carried on tuser
  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PI,
    S_PJ,
    S_SJ,
    S_OJ
  } state_t;

  // controls for the rotate datapath
  typedef struct packed {
    logic mul_en;
    logic sub;
    logic sum_en;
  } rot_ctl_t;

endpackage : rope_sh_pkg
`default_nettype wire

@@ sv/rope_sh_rot.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rope_sh_rot
// Two registered products, then sum or difference, round half up at bit 14
// and saturate to a signed 16-bit result.
// ----------------------------------------------------------------------------
module rope_sh_rot
  import rope_sh_pkg::*;
(
  input  wire logic                     clk,
  input  wire rot_ctl_t                 ctl,
  input  wire logic signed [DATA_W-1:0] x_a,
  input  wire logic signed [DATA_W-1:0] x_b,
  input  wire logic signed [DATA_W-1:0] c_val,
  input  wire logic signed [DATA_W-1:0] s_val,
  output logic signed [DATA_W-1:0]      y
);

  logic signed [2*DATA_W-1:0] p_a;
  logic signed [2*DATA_W-1:0] p_b;
  logic                       sub_q;
  logic signed [2*DATA_W+1:0] sum;
  logic signed [2*DATA_W+1:0] sum_rnd;
  logic signed [19:0]         q;
  logic signed [DATA_W-1:0]   y_next;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_a   <= x_a * c_val;
      p_b   <= x_b * s_val;
      sub_q <= ctl.sub;
    end
  end

  always_comb begin
    if (sub_q) begin
      sum = {{2{p_a[2*DATA_W-1]}}, p_a} - {{2{p_b[2*DATA_W-1]}}, p_b};
    end else begin
      sum = {{2{p_a[2*DATA_W-1]}}, p_a} + {{2{p_b[2*DATA_W-1]}}, p_b};
    end
    sum_rnd = sum + 34'sd8192;
    // floor shift by 14
    q = sum_rnd[33:14];
    if (q[19:15] == 5'b00000 || q[19:15] == 5'b11111) begin
      y_next = q[15:0];
    end else if (q[19]) begin
      y_next = 16'sh8000;
    end else begin
      y_next = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      y <= y_next;
    end
  end

endmodule : rope_sh_rot
`default_nettype wire

@@ sv/rotary_embedding_split_half_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_embedding_split_half_core
// Split-half rotary position rotation over rows of programmable length, with
// the cos/sin table and the first-half elements held in on-chip memories.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tuser: kind, tdata: table or x
// m_axis    out  m_axis_tvalid/tready/tlast  tdata: y_value, out_column
// cfg       in   cfg_wr_en                   cfg_wr_data: row length
//
// table writes and first-half elements are taken back to back
// a second-half element runs in steps: the request cycle reads column i,
// column j is read while the i products form, the j products form while y[i]
// is summed, then two loads of the output register; the shared rotate unit
// and the single output register make these steps run in series
// both memories are undefined after reset and need no clearing pass
// a stalled output holds the core only once its next result is ready
// ----------------------------------------------------------------------------
module rotary_embedding_split_half_core
  import rope_sh_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // column[5:0], cos_value[21:6], sin_value[37:22], x_value[53:38], zero[55:54]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // y_value[15:0], out_column[21:16], zero[23:22]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [HD_W-1:0]        cfg_wr_data
);

  localparam int AW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int BW = (MAX_DIM > 4) ? $clog2(MAX_DIM / 2) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int BUF_DEPTH = MAX_DIM / 2;

  function automatic logic [DW-1:0] eff_dim(input logic [HD_W-1:0] hd);
    int d;
    d = int'(hd) & ~1;
    if (d < 2) d = 2;
    if (d > MAX_DIM) d = MAX_DIM;
    return DW'(d);
  endfunction

  // input fields
  logic [COL_W-1:0]         in_column;
  logic [DATA_W-1:0]        in_cos;
  logic [DATA_W-1:0]        in_sin;
  logic signed [DATA_W-1:0] in_x;

  assign in_column = s_axis_tdata[5:0];
  assign in_cos    = s_axis_tdata[21:6];
  assign in_sin    = s_axis_tdata[37:22];
  assign in_x      = s_axis_tdata[53:38];

  // memories
  logic [2*DATA_W-1:0] tab_mem [MAX_DIM];
  logic [DATA_W-1:0]   buf_mem [BUF_DEPTH];
  logic [2*DATA_W-1:0] tab_rdata;
  logic [DATA_W-1:0]   buf_rdata;

  // control state
  state_t        state;
  state_t        state_next;
  logic [DW-1:0] dim;
  logic [DW-1:0] cnt;
  logic [DW-1:0] cnt_next;

  // per-pair registers
  logic [DW-1:0]            j_idx;
  logic [DW-1:0]            i_idx;
  logic signed [DATA_W-1:0] xj;
  logic                     last_q;

  // output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_y;
  logic [COL_W-1:0]         out_col;
  logic                     out_last;

  logic [DW-1:0] cnt_eff;
  logic [DW-1:0] half;
  logic [DW-1:0] idx_i;
  logic [DW-1:0] cnt_inc;
  logic          is_first;
  logic          in_acc;
  logic          tab_wr;
  logic          first_acc;
  logic          pair_acc;
  logic          tab_rd_en;
  logic [AW-1:0] tab_rd_addr;
  logic          out_load;
  logic          out_sel_j;

  rot_ctl_t                 ctl;
  logic signed [DATA_W-1:0] rot_xa;
  logic signed [DATA_W-1:0] rot_xb;
  logic signed [DATA_W-1:0] rot_y;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cnt_eff   = (cnt >= dim) ? '0 : cnt;
    half      = dim >> 1;
    is_first  = cnt_eff < half;
    idx_i     = cnt_eff - half;
    cnt_inc   = cnt_eff + DW'(1);
    tab_wr    = in_acc && (s_axis_tuser == OP_TABLE) && (int'(in_column) < MAX_DIM);
    first_acc = in_acc && (s_axis_tuser == OP_DATA) && is_first;
    pair_acc  = in_acc && (s_axis_tuser == OP_DATA) && !is_first;
  end

  always_comb begin
    cnt_next = cnt;
    if (first_acc) begin
      cnt_next = cnt_inc;
    end else if (pair_acc) begin
      cnt_next = (cnt_inc >= dim) ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= eff_dim(HD_RESET);
      cnt <= '0;
    end else if (cfg_wr_en) begin
      dim <= eff_dim(cfg_wr_data);
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // one table read port: column i at the pair request, column j in the cycle after
  assign tab_rd_en   = pair_acc || (state == S_PI);
  assign tab_rd_addr = (state == S_PI) ? j_idx[AW-1:0] : idx_i[AW-1:0];

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_mem[AW'(in_column)] <= {in_sin, in_cos};
    end
    if (tab_rd_en) begin
      tab_rdata <= tab_mem[tab_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (first_acc) begin
      buf_mem[cnt_eff[BW-1:0]] <= in_x;
    end
    if (pair_acc) begin
      buf_rdata <= buf_mem[idx_i[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pair_acc) begin
      j_idx  <= cnt_eff;
      i_idx  <= idx_i;
      xj     <= in_x;
      last_q <= (cnt_inc == dim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    out_load   = 1'b0;
    out_sel_j  = 1'b0;
    rot_xa     = xj;
    rot_xb     = buf_rdata;
    case (state)
      S_IDLE: begin
        if (pair_acc) state_next = S_PI;
      end
      S_PI: begin
        // y[i] = x[i]*cos[i] - x[j]*sin[i]
        rot_xa     = buf_rdata;
        rot_xb     = xj;
        ctl.mul_en = 1'b1;
        ctl.sub    = 1'b1;
        state_next = S_PJ;
      end
      S_PJ: begin
        // y[j] = x[j]*cos[j] + x[i]*sin[j], while y[i] is summed
        ctl.mul_en = 1'b1;
        ctl.sum_en = 1'b1;
        state_next = S_SJ;
      end
      S_SJ: begin
        out_load = !out_valid || m_axis_tready;
        ctl.sum_en = out_load;
        if (out_load) state_next = S_OJ;
      end
      S_OJ: begin
        out_load  = !out_valid || m_axis_tready;
        out_sel_j = 1'b1;
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  rope_sh_rot u_rot (
    .clk   (clk),
    .ctl   (ctl),
    .x_a   (rot_xa),
    .x_b   (rot_xb),
    .c_val (tab_rdata[DATA_W-1:0]),
    .s_val (tab_rdata[2*DATA_W-1:DATA_W]),
    .y     (rot_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y    <= rot_y;
      out_col  <= out_sel_j ? COL_W'(j_idx) : COL_W'(i_idx);
      out_last <= out_sel_j && last_q;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_col, out_y};
  assign m_axis_tlast  = out_last;

`ifndef NO_ASSERTIONS
  a_cnt_in_row: assert property (@(posedge clk) disable iff (rst)
    cnt < dim)
    else $error("element counter outside the row");

  a_pair_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_PI) |-> $past(pair_acc))
    else $error("pair sequence started without a pair request");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_col == COL_W'(dim - DW'(1))))
    else $error("row end flagged on a column other than the last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pair_acc |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken while a pair is in flight");
`endif

endmodule : rotary_embedding_split_half_core
`default_nettype wire

@@ verif/rope_sh_checker.sv @@
// ----------------------------------------------------------------------------
// rope_sh_checker
// Watches the request, result and register channels of the split-half rotary
// core. Keeps its own copy of the cos/sin table, the first-half buffer and
// the row position, computes the two rotated elements of every pair and
// matches them in order against the results leaving the core.
// ----------------------------------------------------------------------------
module rope_sh_checker
  import rope_sh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   m_axis_tlast,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [HD_W-1:0]        cfg_wr_data,
  output int                          mismatch_count,
  output int                          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    logic [COL_W-1:0]         col;
    logic                     last;
  } rotated_elem_t;

  rotated_elem_t            expected_y[$];
  logic signed [DATA_W-1:0] cos_tbl [0:MAX_DIM_DEF-1];
  logic signed [DATA_W-1:0] sin_tbl [0:MAX_DIM_DEF-1];
  logic signed [DATA_W-1:0] half_buf [0:MAX_DIM_DEF/2-1];
  logic [HD_W-1:0]          row_len_q;
  int                       elem_idx;
  int                       fails = 0;

  // round half up at bit 14, then clamp to 16 signed bits
  function automatic logic signed [DATA_W-1:0] round_sat_q14(longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[DATA_W-1:0];
  endfunction

  function automatic int row_length(logic [HD_W-1:0] hd);
    int d;
    d = int'({hd[HD_W-1:1], 1'b0});
    if (d < 2) d = 2;
    if (d > MAX_DIM_DEF) d = MAX_DIM_DEF;
    return d;
  endfunction

  always @(posedge clk) begin : track
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] xj;
    logic signed [DATA_W-1:0] xi;
    int                       d;
    int                       half;
    int                       i;
    int                       j;
    longint                   acc;
    rotated_elem_t            want;
    if (rst) begin
      row_len_q = HD_RESET;
      elem_idx = 0;
      expected_y.delete();
    end else begin
      // a register write restarts the row
      if (cfg_wr_en) begin
        row_len_q = cfg_wr_data;
        elem_idx = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_TABLE) begin
          col = s_axis_tdata[5:0];
          cos_tbl[col] = s_axis_tdata[21:6];
          sin_tbl[col] = s_axis_tdata[37:22];
        end else begin
          d = row_length(row_len_q);
          half = d / 2;
          if (elem_idx >= d) elem_idx = 0;
          j = elem_idx;
          xj = s_axis_tdata[53:38];
          if (j < half) begin
            half_buf[j] = xj;
            elem_idx = j + 1;
          end else begin
            i = j - half;
            xi = half_buf[i];
            acc = longint'(xi) * cos_tbl[i] - longint'(xj) * sin_tbl[i];
            expected_y.push_back('{round_sat_q14(acc), COL_W'(i), 1'b0});
            acc = longint'(xj) * cos_tbl[j] + longint'(xi) * sin_tbl[j];
            expected_y.push_back('{round_sat_q14(acc), COL_W'(j), (j + 1 == d)});
            elem_idx = (j + 1 >= d) ? 0 : j + 1;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_y.size() == 0) begin
          $error("unexpected result: y_value %0d out_column %0d",
                 $signed(m_axis_tdata[15:0]), m_axis_tdata[21:16]);
          fails++;
        end else begin
          want = expected_y.pop_front();
          if (m_axis_tdata[15:0] !== want.y) begin
            $error("y_value expected %0d actual %0d", want.y,
                   $signed(m_axis_tdata[15:0]));
            fails++;
          end
          if (m_axis_tdata[21:16] !== want.col) begin
            $error("out_column expected %0d actual %0d", want.col,
                   m_axis_tdata[21:16]);
            fails++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("row_last expected %0d actual %0d", want.last, m_axis_tlast);
            fails++;
          end
        end
      end
    end
    mismatch_count <= fails;
    pending_results <= expected_y.size();
  end

endmodule : rope_sh_checker

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the split-half rotary core: a directed row set on
// a short row length covering saturation, tie rounding and a mid-row table
// update, then random rows over a sweep of row length settings with random
// idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench
  import rope_sh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_wr_en;
  logic [HD_W-1:0]        cfg_wr_data;
  int                     mismatch_count;
  int                     pending_results;
  bit                     calm = 1'b0;
  int                     src_idle_pct = 30;

  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 128;

  rotary_embedding_split_half_core #(.MAX_DIM(MAX_DIM_DEF)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  rope_sh_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side backpressure
  initial begin : sink_side
    int span;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (span) @(posedge clk);
    end
  end

  function automatic logic [DATA_W-1:0] random_q14();
    int v;
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 16384 : -16384;
    else v = int'($urandom_range(0, 32768)) - 16384;
    return DATA_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] random_x();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task automatic push_request(input logic kind, input logic [IN_TDATA_W-1:0] payload);
    int gap;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tuser <= kind;
    s_axis_tdata <= payload;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // unused fields of each request carry random bits, the top two bits stay zero
  task automatic send_table(input logic [COL_W-1:0] col, input logic [DATA_W-1:0] c,
                            input logic [DATA_W-1:0] s);
    push_request(OP_TABLE, {2'b00, DATA_W'($urandom()), s, c, col});
  endtask

  task automatic send_x(input logic [DATA_W-1:0] x);
    push_request(OP_DATA, {2'b00, x, DATA_W'($urandom()), DATA_W'($urandom()),
                           COL_W'($urandom())});
  endtask

  task automatic write_row_len(input logic [HD_W-1:0] hd);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hd;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every pending result, then let in-flight requests settle
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [HD_W-1:0] hd_list [0:7];
    logic [HD_W-1:0] hd;
    hd_list = '{7'd2, 7'd64, 7'd3, 7'd0, 7'd127, 7'd1, 7'd65, 7'd63};
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_TABLE;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows on a four-element head
    write_row_len(7'd4);
    send_table(6'd0, 16'sd16384, -16'sd16384);
    send_table(6'd1, -16'sd16384, 16'sd16384);
    send_table(6'd2, 16'sd16384, 16'sd16384);
    send_table(6'd3, 16'sd8192, 16'sd0);
    send_x(16'h7fff);
    send_x(16'h8000);
    send_x(16'h7fff);                 // positive saturation on both outputs
    send_table(6'd1, 16'sd8192, 16'sd0);  // mid-row update, next pair sees it
    send_x(16'h0001);                 // positive tie rounds up
    send_x(16'h8000);
    send_x(16'h0001);
    send_x(16'h8000);                 // negative saturation
    send_x(16'hffff);                 // negative tie rounds toward zero
    send_table(6'd63, -16'sd16384, -16'sd16384);
    send_x(16'h1234);                 // first half left pending across the write
    drain_results();

    for (int c = 0; c < MAX_DIM_DEF; c++) send_table(COL_W'(c), random_q14(), random_q14());

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      hd = (p < 8) ? hd_list[p] : HD_W'($urandom_range(0, 127));
      if (p == PHASES - 1) calm = 1'b1;
      src_idle_pct = $urandom_range(0, 1) ? 0 : 30;
      write_row_len(hd);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 12)
          send_table(COL_W'($urandom_range(0, 63)), random_q14(), random_q14());
        else
          send_x(random_x());
      end
    end
    drain_results();

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : testbench
